>>> design/jacd_pkg.sv
// ----------------------------------------------------------------------------
// jacd_pkg
// Shared types and constants for the joystick axis calibration block.
// ----------------------------------------------------------------------------
package jacd_pkg;

   // Q1.15 full scale (+1.0) and twice full scale
   localparam logic [14:0] Q_ONE = 15'd32767;
   localparam logic [15:0] TWO_Q = 16'd65534;

   // opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CAL    = 1'b1;

   // register file
   localparam int unsigned CSR_AW = 4;
   localparam logic [1:0] REG_DEADZONE   = 2'd0;
   localparam logic [1:0] REG_REPORT_MIN = 2'd1;
   localparam logic [1:0] REG_REPORT_MAX = 2'd2;

   // sample plus the calibration of its axis, front to back
   typedef struct packed {
      logic signed [15:0] sample;
      logic signed [15:0] low;
      logic signed [15:0] centre;
      logic signed [15:0] high;
   } item_type;

endpackage

>>> design/joystick_axis_calibrate_deadzone.sv
// ----------------------------------------------------------------------------
// joystick_axis_calibrate_deadzone
// Per-axis min/centre/max calibration, scaled radial deadzone, report scaling.
// ----------------------------------------------------------------------------
//  channel  | ports                   | word
//  ---------+-------------------------+--------------------------------------
//  request  | req_push / req_full     | opcode, axis, sample, cal low/ctr/high
//  response | rsp_pop / rsp_empty     | clean value, report value
//  csr      | APB psel/penable/pwrite | deadzone, report_min, report_max
//
//  One word per cycle sustained while the queues have room. A sample's response
//  word passes the front queue, two bit-per-stage dividers (15 + 15 stages),
//  eight single registers (stages A through H) and the response queue write.
//  Calibration words update the axis table at accept and give no response.
//  Synchronous reset restores the default calibration and register values.
//  A full response queue stalls the whole back pipeline; a 4-word queue in
//  front keeps accepting until it fills.
// ----------------------------------------------------------------------------
module joystick_axis_calibrate_deadzone import jacd_pkg::*; #(
   parameter int NUM_AXES = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_opcode,
   input  logic [2:0]         req_axis_index,
   input  logic signed [15:0] req_sample_value,
   input  logic signed [15:0] req_cal_low,
   input  logic signed [15:0] req_cal_centre,
   input  logic signed [15:0] req_cal_high,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_clean_value,
   output logic signed [15:0] rsp_report_value,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // config registers, word aligned
   logic [14:0]        deadzone_ff;
   logic signed [15:0] rmin_ff, rmax_ff;
   logic               csr_wr;
   logic [1:0]         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= '0;
         rmin_ff     <= 16'sd0;
         rmax_ff     <= 16'sd32767;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DEADZONE:   deadzone_ff <= csr_pwdata[14:0];
            REG_REPORT_MIN: rmin_ff     <= csr_pwdata[15:0];
            REG_REPORT_MAX: rmax_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DEADZONE:   csr_prdata = {17'd0, deadzone_ff};
         REG_REPORT_MIN: csr_prdata = 32'(rmin_ff);
         REG_REPORT_MAX: csr_prdata = 32'(rmax_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // front: accept, table, sample queue
   logic     q_vld, q_pop;
   item_type q_item;

   jacd_front #(.NUM_AXES(NUM_AXES)) u_front (
      .clock, .reset,
      .req_push, .req_full, .req_opcode, .req_axis_index, .req_sample_value,
      .req_cal_low, .req_cal_centre, .req_cal_high,
      .q_vld, .q_item, .q_pop
   );

   // back: map, deadzone, report, response queue
   jacd_back u_back (
      .clock, .reset,
      .q_vld, .q_item, .q_pop,
      .deadzone(deadzone_ff), .report_min(rmin_ff), .report_max(rmax_ff),
      .rsp_empty, .rsp_pop, .rsp_clean_value, .rsp_report_value
   );

endmodule

>>> design/jacd_div.sv
// ----------------------------------------------------------------------------
// jacd_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module jacd_div #(
   parameter int NW = 31,
   parameter int DW = 16,
   parameter int QW = 15,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_vld,
   output logic [QW-1:0] out_quot,
   output logic [SW-1:0] out_side
);

   localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;

   logic [NW-1:0] rem_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [SW-1:0] side_ff [QW];
   logic [QW-1:0] vld_ff;

   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic [NW-1:0] rem_p;
      logic [QW-1:0] quo_p;
      logic [DW-1:0] den_p;
      logic [SW-1:0] side_p;
      logic          vld_p;
      logic [WW-1:0] rem_w;
      logic [WW-1:0] sub_w;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (g == 0) begin : g_first
         assign rem_p  = in_num;
         assign quo_p  = '0;
         assign den_p  = in_den;
         assign side_p = in_side;
         assign vld_p  = in_vld;
      end else begin : g_next
         assign rem_p  = rem_ff[g-1];
         assign quo_p  = quo_ff[g-1];
         assign den_p  = den_ff[g-1];
         assign side_p = side_ff[g-1];
         assign vld_p  = vld_ff[g-1];
      end

      always_comb begin
         rem_w = WW'(rem_p);
         sub_w = WW'(den_p) << (QW - 1 - g);
         if (rem_w >= sub_w) begin
            rem_in = NW'(rem_w - sub_w);
            quo_in = quo_p | (QW'(1) << (QW - 1 - g));
         end else begin
            rem_in = rem_p;
            quo_in = quo_p;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            quo_ff[g]  <= quo_in;
            den_ff[g]  <= den_p;
            side_ff[g] <= side_p;
         end
      end
   end

   assign out_vld  = vld_ff[QW-1];
   assign out_quot = quo_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule

>>> design/jacd_front.sv
// ----------------------------------------------------------------------------
// jacd_front
// Accepts words, keeps the per-axis calibration, queues samples for the back.
// ----------------------------------------------------------------------------
module jacd_front import jacd_pkg::*; #(
   parameter int NUM_AXES = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_opcode,
   input  logic [2:0]         req_axis_index,
   input  logic signed [15:0] req_sample_value,
   input  logic signed [15:0] req_cal_low,
   input  logic signed [15:0] req_cal_centre,
   input  logic signed [15:0] req_cal_high,
   output logic               q_vld,
   output item_type           q_item,
   input  logic               q_pop
);

   localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam int QD = 4;

   logic signed [15:0] low_ff    [NUM_AXES];
   logic signed [15:0] centre_ff [NUM_AXES];
   logic signed [15:0] high_ff   [NUM_AXES];

   item_type  que_ff [QD];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;

   logic       accept, axis_ok, push;
   logic [AW-1:0] idx;
   item_type   item_in;

   assign accept  = req_push && !req_full;
   assign axis_ok = 32'({1'b0, req_axis_index}) < NUM_AXES;
   assign idx     = AW'({1'b0, req_axis_index});
   assign push    = accept && axis_ok && (req_opcode == OP_SAMPLE);

   always_comb begin
      item_in.sample = req_sample_value;
      item_in.low    = low_ff[idx];
      item_in.centre = centre_ff[idx];
      item_in.high   = high_ff[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            low_ff[i]    <= -16'sd32767;
            centre_ff[i] <= 16'sd0;
            high_ff[i]   <= 16'sd32767;
         end
      end else if (accept && axis_ok && (req_opcode == OP_CAL)) begin
         low_ff[idx]    <= req_cal_low;
         centre_ff[idx] <= req_cal_centre;
         high_ff[idx]   <= req_cal_high;
      end
   end

   // sample queue
   always_ff @(posedge clock) begin
      if (push) begin
         que_ff[wr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (q_pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(q_pop);
      end
   end

   assign req_full = (cnt_ff == 3'(QD));
   assign q_vld    = (cnt_ff != 3'd0);
   assign q_item   = que_ff[rd_ff];

endmodule

>>> design/jacd_back.sv
// ----------------------------------------------------------------------------
// jacd_back
// Calibration map, deadzone and report scaling pipeline with result queue.
// ----------------------------------------------------------------------------
module jacd_back import jacd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_vld,
   input  item_type           q_item,
   output logic               q_pop,
   input  logic [14:0]        deadzone,
   input  logic signed [15:0] report_min,
   input  logic signed [15:0] report_max,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_clean_value,
   output logic signed [15:0] rsp_report_value
);

   logic adv;

   // ---- stage A: segment select and clamp
   logic        a_vld_ff;
   logic [15:0] a_num_ff, a_den_ff;
   logic        a_spec_ff, a_neg_ff;
   logic [14:0] a_smag_ff;
   logic [15:0] a_num_in, a_den_in;
   logic        a_spec_in, a_neg_in;
   logic [14:0] a_smag_in;
   logic signed [16:0] s17, l17, m17, h17, dpos, dneg, sc;

   assign q_pop = adv && q_vld;

   always_comb begin
      s17 = 17'(q_item.sample);
      l17 = 17'(q_item.low);
      m17 = 17'(q_item.centre);
      h17 = 17'(q_item.high);
      dpos = h17 - m17;
      dneg = m17 - l17;
      a_spec_in = 1'b1;
      a_smag_in = '0;
      a_neg_in  = 1'b0;
      a_num_in  = '0;
      a_den_in  = '0;
      sc        = s17;
      if (s17 > m17) begin
         if (dpos <= 17'sd0) begin
            a_smag_in = Q_ONE;
         end else begin
            sc = (s17 > h17) ? h17 : s17;
            a_spec_in = 1'b0;
            a_num_in  = 16'(sc - m17);
            a_den_in  = dpos[15:0];
         end
      end else if (s17 < m17) begin
         a_neg_in = 1'b1;
         if (dneg == 17'sd0) begin
            a_smag_in = Q_ONE;
         end else if (dneg > 17'sd0) begin
            sc = (s17 < l17) ? l17 : s17;
            a_spec_in = 1'b0;
            a_num_in  = 16'(m17 - sc);
            a_den_in  = dneg[15:0];
         end
      end
   end

   // ---- stage B: scale by full scale
   logic        b_vld_ff;
   logic [30:0] b_prod_ff;
   logic [15:0] b_den_ff;
   logic [16:0] b_side_ff;

   // ---- divider 1 -> stage C
   logic        d1_vld;
   logic [14:0] d1_q;
   logic [16:0] d1_side;

   jacd_div #(.NW(31), .DW(16), .QW(15), .SW(17)) u_div_cal (
      .clock, .reset, .en(adv),
      .in_vld(b_vld_ff), .in_num(b_prod_ff), .in_den(b_den_ff), .in_side(b_side_ff),
      .out_vld(d1_vld), .out_quot(d1_q), .out_side(d1_side)
   );

   logic        c_vld_ff, c_zero_ff, c_full_ff, c_neg_ff;
   logic [14:0] c_num_ff, c_span_ff;
   logic [14:0] c_mag;
   assign c_mag = d1_side[16] ? d1_side[15:1] : d1_q;

   // ---- stage D
   logic        e_vld_ff;
   logic [29:0] e_prod_ff;
   logic [14:0] e_span_ff;
   logic [2:0]  e_side_ff;

   logic        d2_vld;
   logic [14:0] d2_q;
   logic [2:0]  d2_side;

   jacd_div #(.NW(30), .DW(15), .QW(15), .SW(3)) u_div_dz (
      .clock, .reset, .en(adv),
      .in_vld(e_vld_ff), .in_num(e_prod_ff), .in_den(e_span_ff), .in_side(e_side_ff),
      .out_vld(d2_vld), .out_quot(d2_q), .out_side(d2_side)
   );

   // ---- stage E: signed clean value
   logic               f_vld_ff;
   logic signed [15:0] f_v_ff;
   logic [14:0]        f_m;
   assign f_m = d2_side[2] ? 15'd0 : (d2_side[1] ? Q_ONE : d2_q);

   // ---- stage F: report products
   logic               g_vld_ff;
   logic signed [32:0] g_p1_ff;
   logic signed [33:0] g_p2_ff;
   logic signed [15:0] g_v_ff;
   logic signed [16:0] diff, off;
   assign diff = 17'(report_max) - 17'(report_min);
   assign off  = 17'(f_v_ff) + 17'sd32767;

   // ---- stage G: sum and magnitude
   logic               h_vld_ff;
   logic [31:0]        h_abs_ff;
   logic [16:0]        h_side_ff;
   logic signed [34:0] num;
   assign num = 35'(g_p1_ff) + 35'(g_p2_ff);

   // ---- stage H: divide by 65534
   // estimate is magnitude >> 16, remainder is low half plus twice the
   // estimate, which stays below three divisors; fix up by two compares
   logic        i_vld_ff;
   logic [15:0] i_q0_ff;
   logic [17:0] i_r_ff;
   logic [16:0] i_side_ff;

   logic        d3_vld;
   logic [16:0] d3_q;
   logic [16:0] d3_side;

   assign d3_vld  = i_vld_ff;
   assign d3_side = i_side_ff;
   assign d3_q    = 17'(i_q0_ff) + 17'(i_r_ff >= 18'(TWO_Q))
                    + 17'(i_r_ff >= 18'({TWO_Q, 1'b0}));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= q_vld;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= d1_vld;
         e_vld_ff <= c_vld_ff;
         f_vld_ff <= d2_vld;
         g_vld_ff <= f_vld_ff;
         h_vld_ff <= g_vld_ff;
         i_vld_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_num_ff  <= a_num_in;
         a_den_ff  <= a_den_in;
         a_spec_ff <= a_spec_in;
         a_neg_ff  <= a_neg_in;
         a_smag_ff <= a_smag_in;

         b_prod_ff <= 31'(a_num_ff) * 31'(Q_ONE);
         b_den_ff  <= a_den_ff;
         b_side_ff <= {a_spec_ff, a_smag_ff, a_neg_ff};

         // below the deadzone (or zero) reads as zero
         c_zero_ff <= (c_mag == 15'd0) || (c_mag < deadzone);
         c_full_ff <= (deadzone == Q_ONE);
         c_neg_ff  <= d1_side[0];
         c_num_ff  <= c_mag - deadzone;
         c_span_ff <= Q_ONE - deadzone;

         e_prod_ff <= 30'(c_num_ff) * 30'(Q_ONE);
         e_span_ff <= c_span_ff;
         e_side_ff <= {c_zero_ff, c_full_ff, c_neg_ff};

         f_v_ff <= d2_side[0] ? -16'({1'b0, f_m}) : 16'({1'b0, f_m});

         g_p1_ff <= 33'(report_min) * 33'sd65534;
         g_p2_ff <= 34'(diff) * 34'(off);
         g_v_ff  <= f_v_ff;

         h_abs_ff  <= num[34] ? 32'(-num) : 32'(num);
         h_side_ff <= {g_v_ff, num[34]};

         i_q0_ff   <= h_abs_ff[31:16];
         i_r_ff    <= 18'(h_abs_ff[15:0]) + 18'({h_abs_ff[31:16], 1'b0});
         i_side_ff <= h_side_ff;
      end
   end

   // ---- result queue, two entries
   logic [15:0] oc_ff [2];
   logic [15:0] or_ff [2];
   logic        owr_ff, ord_ff;
   logic [1:0]  ocnt_ff;
   logic        opush, opop;
   logic [16:0] rq;

   assign adv   = (ocnt_ff != 2'd2);
   assign opush = adv && d3_vld;
   assign opop  = rsp_pop && !rsp_empty;
   assign rq    = d3_side[0] ? -d3_q : d3_q;

   always_ff @(posedge clock) begin
      if (opush) begin
         oc_ff[owr_ff] <= d3_side[16:1];
         or_ff[owr_ff] <= rq[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
         ocnt_ff <= '0;
      end else begin
         if (opush) owr_ff <= !owr_ff;
         if (opop) ord_ff <= !ord_ff;
         ocnt_ff <= ocnt_ff + 2'(opush) - 2'(opop);
      end
   end

   assign rsp_empty        = (ocnt_ff == 2'd0);
   assign rsp_clean_value  = oc_ff[ord_ff];
   assign rsp_report_value = or_ff[ord_ff];

`ifndef SYNTH
   a_ocnt_range: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff != 2'd3) else $error("result queue count out of range");
   a_clean_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_clean_value != -16'sd32768) else $error("clean value out of range");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(h_vld_ff) && $stable(a_vld_ff)) else $error("pipeline moved while stalled");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty) else $error("results present after reset");
`endif

endmodule
